### design/gps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the greedy polyline simplifier.
// No dependencies.
package gps_pkg;

  localparam int unsigned CoordW  = 16;          // one coordinate
  localparam int unsigned PointW  = 2 * CoordW;  // packed point, y above x
  localparam int unsigned MaxDevW = 16;          // deviation register

  // Sequencer states, one-hot.
  typedef enum logic [21:0] {
    ST_LOAD     = 22'h000001,
    ST_START    = 22'h000002,
    ST_MD2      = 22'h000004,
    ST_EMIT_RD  = 22'h000008,
    ST_EMIT_CAP = 22'h000010,
    ST_OUT      = 22'h000020,
    ST_SEARCH   = 22'h000040,
    ST_J_CAP    = 22'h000080,
    ST_LEN_X    = 22'h000100,
    ST_LEN_Y    = 22'h000200,
    ST_LEN_SUM  = 22'h000400,
    ST_RHS_LO   = 22'h000800,
    ST_RHS_HI   = 22'h001000,
    ST_RHS_SUM  = 22'h002000,
    ST_K_RD     = 22'h004000,
    ST_K_CAP    = 22'h008000,
    ST_CR1      = 22'h010000,
    ST_CR2      = 22'h020000,
    ST_CR3      = 22'h040000,
    ST_SQ_LO    = 22'h080000,
    ST_SQ_HI    = 22'h100000,
    ST_SQ_CMP   = 22'h200000
  } state_e;

endpackage

### design/greedy_polyline_simplifier_unit.sv
`timescale 1ns / 1ps
// Greedy polyline simplifier: point store, shared multiplier and sequencer.
// Depends on gps_pkg.
//
//  channel   | direction | request fields
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tdata: point_x [15:0], point_y [31:16]; tlast: last
//  m_axis    | out       | tdata: kept_x [15:0], kept_y [31:16];
//            |           | tlast: end_of_path; tuser: overflowed
//  cfg       | in        | cfg_data_i: max_deviation
//
// Loading accepts one point per cycle; s_axis_tready is high only while loading.
// After the last point the sequencer squares max_deviation, then emits each kept point
// and waits on m_axis_tready. A shortcut test finds the candidate's squared length and
// then squares the cross product of each intermediate point, all through one shared
// 33x18 multiplier; a candidate that coincides with the anchor is skipped.
// Reset clears the sequencer, point count, overflow flag and deviation register.
module greedy_polyline_simplifier_unit #(
  parameter int unsigned MAX_POINTS = 64  // store depth, 3..64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gps_pkg::PointW-1:0]    s_axis_tdata,   // point_x, point_y
  input  logic                          s_axis_tlast,   // last_point
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gps_pkg::PointW-1:0]    m_axis_tdata,   // kept_x, kept_y
  output logic                          m_axis_tlast,   // end_of_path
  output logic                          m_axis_tuser,   // overflowed
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gps_pkg::MaxDevW-1:0]   cfg_data_i      // max_deviation
);
  import gps_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned MA = 33;  // multiplier operand a
  localparam int unsigned MB = 18;  // multiplier operand b
  localparam int unsigned MP = MA + MB;
  localparam int unsigned WW = 66;  // squared-distance compare width

  // magnitude of a coordinate difference, always below 2^16
  function automatic logic [CoordW-1:0] mag16(input logic [CoordW:0] v);
    logic [CoordW:0] n;
    n = ~v + 1'b1;
    return v[CoordW] ? n[CoordW-1:0] : v[CoordW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [PointW-1:0] mem [MAX_POINTS];
  logic [PointW-1:0] rd_q;
  logic [AW-1:0]     rd_addr;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [MaxDevW-1:0] maxdev_q, maxdev_d;
  logic [31:0]        md2_q, md2_d;
  logic [CoordW-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic [CoordW:0]    ux_q, ux_d, uy_q, uy_d, dx_q, dx_d, dy_q, dy_d;
  logic [32:0]        len2_q, len2_d;
  logic [WW-1:0]      rhs_q, rhs_d, sq_q, sq_d;
  logic [33:0]        cr_q, cr_d;
  logic [AW-1:0]      i_q, i_d, j_q, j_d, k_q, k_d, e_q, e_d;
  logic [MP-1:0]      mul_q, mul_d;
  logic [MA-1:0]      mul_a;
  logic [MB-1:0]      mul_b;

  logic               ov_q, ov_d;
  logic [PointW-1:0]  od_q, od_d;
  logic               ol_q, ol_d, ou_q, ou_d;

  logic               accept;
  logic [32:0]        len_sum;
  logic [WW-1:0]      wide_sum;
  logic [33:0]        prod_s, prod_n;
  logic [32:0]        cr_mag;
  logic [33:0]        cr_neg;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = ou_q;

  assign len_sum  = len2_q + mul_q[32:0];
  assign prod_s   = {2'b00, mul_q[31:0]};
  assign prod_n   = ~prod_s + 1'b1;
  assign cr_neg   = ~cr_q + 1'b1;
  assign cr_mag   = cr_q[33] ? cr_neg[32:0] : cr_q[32:0];
  // partial product of the high operand slice, weight 2^18
  assign wide_sum = (state_q == ST_RHS_SUM ? rhs_q : sq_q) + {mul_q[47:0], 18'b0};

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_START: begin
        mul_a = MA'(maxdev_q);
        mul_b = MB'(maxdev_q);
      end
      ST_LEN_X: begin
        mul_a = MA'(mag16(ux_q));
        mul_b = MB'(mag16(ux_q));
      end
      ST_LEN_Y: begin
        mul_a = MA'(mag16(uy_q));
        mul_b = MB'(mag16(uy_q));
      end
      ST_RHS_LO: begin
        mul_a = len2_q;
        mul_b = md2_q[17:0];
      end
      ST_RHS_HI: begin
        mul_a = len2_q;
        mul_b = MB'(md2_q[31:18]);
      end
      ST_CR1: begin
        mul_a = MA'(mag16(dx_q));
        mul_b = MB'(mag16(uy_q));
      end
      ST_CR2: begin
        mul_a = MA'(mag16(dy_q));
        mul_b = MB'(mag16(ux_q));
      end
      ST_SQ_LO: begin
        mul_a = cr_mag;
        mul_b = cr_mag[17:0];
      end
      ST_SQ_HI: begin
        mul_a = cr_mag;
        mul_b = MB'(cr_mag[32:18]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_d = MP'(mul_a) * MP'(mul_b);

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    maxdev_d = cfg_valid_i ? cfg_data_i : maxdev_q;
    md2_d    = md2_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    ux_d     = ux_q;
    uy_d     = uy_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    len2_d   = len2_q;
    rhs_d    = rhs_q;
    sq_d     = sq_q;
    cr_d     = cr_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    e_d      = e_q;
    ov_d     = ov_q;
    od_d     = od_q;
    ol_d     = ol_q;
    ou_d     = ou_q;
    rd_addr  = e_q;

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_q < CW'(MAX_POINTS)) cnt_d = cnt_q + 1'b1;
          else                          ovf_d = 1'b1;
          if (s_axis_tlast) state_d = ST_START;
        end
      end
      ST_START: state_d = ST_MD2;  // max_deviation squared
      ST_MD2: begin
        md2_d   = mul_q[31:0];
        e_d     = '0;
        state_d = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        rd_addr = e_q;
        state_d = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        // emitted point becomes the anchor
        ov_d    = 1'b1;
        od_d    = rd_q;
        ol_d    = (CW'(e_q) == cnt_q - 1'b1);
        ou_d    = ovf_q;
        ax_d    = rd_q[CoordW-1:0];
        ay_d    = rd_q[PointW-1:CoordW];
        i_d     = e_q;
        j_d     = AW'(cnt_q - 1'b1);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          ov_d = 1'b0;
          if (ol_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        rd_addr = j_q;
        if ({1'b0, j_q} > ({1'b0, i_q} + (AW+1)'(1))) begin
          state_d = ST_J_CAP;
        end else begin
          // nothing farther qualified: take the next point
          e_d     = i_q + 1'b1;
          state_d = ST_EMIT_RD;
        end
      end
      ST_J_CAP: begin
        ux_d    = {rd_q[CoordW-1], rd_q[CoordW-1:0]} - {ax_q[CoordW-1], ax_q};
        uy_d    = {rd_q[PointW-1], rd_q[PointW-1:CoordW]} - {ay_q[CoordW-1], ay_q};
        state_d = ST_LEN_X;
      end
      ST_LEN_X: state_d = ST_LEN_Y;
      ST_LEN_Y: begin
        len2_d  = mul_q[32:0];
        state_d = ST_LEN_SUM;
      end
      ST_LEN_SUM: begin
        len2_d = len_sum;
        if (len_sum == '0) begin
          // candidate coincides with the anchor
          j_d     = j_q - 1'b1;
          state_d = ST_SEARCH;
        end else begin
          state_d = ST_RHS_LO;
        end
      end
      ST_RHS_LO: state_d = ST_RHS_HI;
      ST_RHS_HI: begin
        rhs_d   = WW'(mul_q);
        state_d = ST_RHS_SUM;
      end
      ST_RHS_SUM: begin
        rhs_d   = wide_sum;
        k_d     = i_q + 1'b1;
        state_d = ST_K_RD;
      end
      ST_K_RD: begin
        rd_addr = k_q;
        if (k_q == j_q) begin
          // all intermediate points within bounds
          e_d     = j_q;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_K_CAP;
        end
      end
      ST_K_CAP: begin
        dx_d    = {rd_q[CoordW-1], rd_q[CoordW-1:0]} - {ax_q[CoordW-1], ax_q};
        dy_d    = {rd_q[PointW-1], rd_q[PointW-1:CoordW]} - {ay_q[CoordW-1], ay_q};
        state_d = ST_CR1;
      end
      ST_CR1: state_d = ST_CR2;
      ST_CR2: begin
        cr_d    = (dx_q[CoordW] ^ uy_q[CoordW]) ? prod_n : prod_s;
        state_d = ST_CR3;
      end
      ST_CR3: begin
        cr_d    = (dy_q[CoordW] ^ ux_q[CoordW]) ? cr_q + prod_s : cr_q - prod_s;
        state_d = ST_SQ_LO;
      end
      ST_SQ_LO: state_d = ST_SQ_HI;
      ST_SQ_HI: begin
        sq_d    = WW'(mul_q);
        state_d = ST_SQ_CMP;
      end
      ST_SQ_CMP: begin
        if (wide_sum > rhs_q) begin
          j_d     = j_q - 1'b1;
          state_d = ST_SEARCH;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_K_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // point store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q < CW'(MAX_POINTS))) mem[cnt_q[AW-1:0]] <= s_axis_tdata;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      maxdev_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      maxdev_q <= maxdev_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    md2_q  <= md2_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    ux_q   <= ux_d;
    uy_q   <= uy_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    len2_q <= len2_d;
    rhs_q  <= rhs_d;
    sq_q   <= sq_d;
    cr_q   <= cr_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    e_q    <= e_d;
    mul_q  <= mul_d;
    od_q   <= od_d;
    ol_q   <= ol_d;
    ou_q   <= ou_d;
  end

endmodule
